@@ hw/rtl/vrtc_pkg.sv @@
// Shared types and codes for the vertex removal tree check block.
package vrtc_pkg;

  localparam int unsigned ModeW    = 2;
  localparam int unsigned VtxW     = 4;
  localparam int unsigned VerdictW = 2;
  localparam int unsigned VcountW  = 5;

  localparam logic [VcountW-1:0] VcountReset = 5'd16;

  localparam logic [ModeW-1:0] MODE_CLEAR = 2'd0;
  localparam logic [ModeW-1:0] MODE_ADD   = 2'd1;
  localparam logic [ModeW-1:0] MODE_EVAL  = 2'd2;

  localparam logic [VerdictW-1:0] VERDICT_TREE  = 2'd0;
  localparam logic [VerdictW-1:0] VERDICT_DISC  = 2'd1;
  localparam logic [VerdictW-1:0] VERDICT_CYCLE = 2'd2;

  // Control strobes from the sequencer to the graph store.
  typedef struct packed {
    logic clr;
    logic wr_en;
    logic rd_en;
  } store_req_t;

  // One verdict handed from the sequencer to the output register.
  typedef struct packed {
    logic                last;
    logic [VerdictW-1:0] verdict;
    logic [VtxW-1:0]     vertex;
  } result_t;

endpackage

@@ hw/rtl/vrtc_graph_store.sv @@
// Adjacency and repeated-edge row memory with per-row valid bits.
module vrtc_graph_store
  import vrtc_pkg::*;
#(
  parameter int unsigned MAX_V = 16,
  localparam int unsigned VW   = (MAX_V > 1) ? $clog2(MAX_V) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  store_req_t       req_i,
  input  logic [VW-1:0]    rd_addr_i,
  input  logic [VW-1:0]    wr_addr_i,
  input  logic [MAX_V-1:0] wr_adj_i,
  input  logic [MAX_V-1:0] wr_rep_i,
  output logic [MAX_V-1:0] rd_adj_o,
  output logic [MAX_V-1:0] rd_rep_o
);

  logic [2*MAX_V-1:0] mem [MAX_V];
  logic [MAX_V-1:0]   row_vld_q;
  logic [2*MAX_V-1:0] rd_data_q;
  logic               rd_vld_q;

  // A row that was never written since the last clear reads as empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (req_i.clr) begin
        row_vld_q <= '0;
      end else if (req_i.wr_en) begin
        row_vld_q[wr_addr_i] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= row_vld_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[wr_addr_i] <= {wr_rep_i, wr_adj_i};
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_adj_o = rd_vld_q ? rd_data_q[MAX_V-1:0] : '0;
  assign rd_rep_o = rd_vld_q ? rd_data_q[2*MAX_V-1:MAX_V] : '0;

endmodule

@@ hw/rtl/vrtc_ctrl.sv @@
// Sequencer: edge insertion, stack-based walk and edge count per removed vertex.
module vrtc_ctrl
  import vrtc_pkg::*;
#(
  parameter int unsigned MAX_V = 16,
  localparam int unsigned VW   = (MAX_V > 1) ? $clog2(MAX_V) : 1,
  localparam int unsigned NW   = $clog2(MAX_V + 1),
  localparam int unsigned CW   = $clog2(MAX_V * MAX_V + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [NW-1:0]    n_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ModeW-1:0] mode_i,
  input  logic [VtxW-1:0]  src_i,
  input  logic [VtxW-1:0]  dst_i,
  input  logic             res_free_i,
  output logic             res_valid_o,
  output result_t          res_o,
  output store_req_t       st_req_o,
  output logic [VW-1:0]    st_rd_addr_o,
  output logic [VW-1:0]    st_wr_addr_o,
  output logic [MAX_V-1:0] st_wr_adj_o,
  output logic [MAX_V-1:0] st_wr_rep_o,
  input  logic [MAX_V-1:0] st_rd_adj_i,
  input  logic [MAX_V-1:0] st_rd_rep_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD_S, S_ADD_D, S_W_INIT, S_W_POP, S_W_ADDR, S_W_LOAD, S_W_PUSH,
    S_C_RD, S_C_ACC, S_EMIT
  } state_e;

  state_e              state_q, state_d;
  logic [VW-1:0]       s_q, s_d, d_q, d_d;
  logic                dup_q, dup_d;
  logic [VW-1:0]       v_q, v_d;
  logic [NW-1:0]       sp_q, sp_d;
  logic [MAX_V-1:0]    visited_q, visited_d;
  logic [MAX_V-1:0]    nb_q, nb_d;
  logic [NW-1:0]       row_q, row_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [VerdictW-1:0] verdict_q, verdict_d;

  logic [VW-1:0]    stk_mem [MAX_V];
  logic [VW-1:0]    stk_rd_q;
  logic             stk_we, stk_re;
  logic [VW-1:0]    stk_waddr, stk_raddr, stk_wdata;

  logic             accept;
  logic [MAX_V-1:0] keep, above, lowest;
  logic [VW-1:0]    low_idx, start;
  logic [CW-1:0]    pop_sum;
  logic             connected;
  logic             last_v;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign last_v     = (NW'(v_q) == n_i - NW'(1));
  assign start      = last_v ? '0 : VW'(NW'(v_q) + NW'(1));

  // Vertices that stay in the graph while v is removed; bits above the
  // current row for the edge count.
  always_comb begin
    for (int j = 0; j < MAX_V; j++) begin
      keep[j]  = (32'(j) < 32'(n_i)) && (32'(j) != 32'(v_q));
      above[j] = (32'(j) > 32'(row_q));
    end
  end

  assign connected = ((visited_q & keep) == keep);

  // Lowest pending neighbor.
  always_comb begin
    low_idx = '0;
    for (int j = MAX_V - 1; j >= 0; j--) begin
      if (nb_q[j]) begin
        low_idx = VW'(j);
      end
    end
    lowest = MAX_V'(1) << low_idx;
  end

  // Shared counting unit: edges and repeat marks of one row above the diagonal.
  always_comb begin
    pop_sum = '0;
    for (int j = 0; j < MAX_V; j++) begin
      pop_sum = pop_sum + CW'(st_rd_adj_i[j] & keep[j] & above[j])
                        + CW'(st_rd_rep_i[j] & keep[j] & above[j]);
    end
  end

  always_comb begin
    state_d      = state_q;
    s_d          = s_q;
    d_d          = d_q;
    dup_d        = dup_q;
    v_d          = v_q;
    sp_d         = sp_q;
    visited_d    = visited_q;
    nb_d         = nb_q;
    row_d        = row_q;
    cnt_d        = cnt_q;
    verdict_d    = verdict_q;
    st_req_o     = '0;
    st_rd_addr_o = '0;
    st_wr_addr_o = '0;
    st_wr_adj_o  = '0;
    st_wr_rep_o  = '0;
    stk_we       = 1'b0;
    stk_re       = 1'b0;
    stk_waddr    = '0;
    stk_raddr    = '0;
    stk_wdata    = '0;
    res_valid_o  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (mode_i)
            MODE_CLEAR: st_req_o.clr = 1'b1;
            MODE_ADD: begin
              if (!(src_i == dst_i || 32'(src_i) >= 32'(n_i) ||
                    32'(dst_i) >= 32'(n_i))) begin
                s_d             = VW'(src_i);
                d_d             = VW'(dst_i);
                st_req_o.rd_en  = 1'b1;
                st_rd_addr_o    = VW'(src_i);
                state_d         = S_ADD_S;
              end
            end
            MODE_EVAL: begin
              v_d     = '0;
              state_d = S_W_INIT;
            end
            default: ;
          endcase
        end
      end
      S_ADD_S: begin
        dup_d          = st_rd_adj_i[d_q];
        st_req_o.wr_en = 1'b1;
        st_wr_addr_o   = s_q;
        st_wr_adj_o    = st_rd_adj_i | (MAX_V'(1) << d_q);
        st_wr_rep_o    = st_rd_rep_i | (MAX_V'(st_rd_adj_i[d_q]) << d_q);
        st_req_o.rd_en = 1'b1;
        st_rd_addr_o   = d_q;
        state_d        = S_ADD_D;
      end
      S_ADD_D: begin
        st_req_o.wr_en = 1'b1;
        st_wr_addr_o   = d_q;
        st_wr_adj_o    = st_rd_adj_i | (MAX_V'(1) << s_q);
        st_wr_rep_o    = st_rd_rep_i | (MAX_V'(dup_q) << s_q);
        state_d        = S_IDLE;
      end
      S_W_INIT: begin
        visited_d = MAX_V'(1) << start;
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wdata = start;
        sp_d      = NW'(1);
        state_d   = S_W_POP;
      end
      S_W_POP: begin
        if (sp_q == '0) begin
          if (!connected) begin
            verdict_d = VERDICT_DISC;
            state_d   = S_EMIT;
          end else begin
            row_d   = '0;
            cnt_d   = '0;
            state_d = S_C_RD;
          end
        end else begin
          sp_d      = sp_q - NW'(1);
          stk_re    = 1'b1;
          stk_raddr = VW'(sp_q - NW'(1));
          state_d   = S_W_ADDR;
        end
      end
      S_W_ADDR: begin
        st_req_o.rd_en = 1'b1;
        st_rd_addr_o   = stk_rd_q;
        state_d        = S_W_LOAD;
      end
      S_W_LOAD: begin
        nb_d    = st_rd_adj_i & keep & ~visited_q;
        state_d = S_W_PUSH;
      end
      S_W_PUSH: begin
        if (nb_q == '0) begin
          state_d = S_W_POP;
        end else begin
          visited_d = visited_q | lowest;
          nb_d      = nb_q & ~lowest;
          stk_we    = 1'b1;
          stk_waddr = VW'(sp_q);
          stk_wdata = low_idx;
          sp_d      = sp_q + NW'(1);
        end
      end
      S_C_RD: begin
        if (row_q == n_i) begin
          verdict_d = (cnt_q != (CW'(n_i) - CW'(2))) ? VERDICT_CYCLE : VERDICT_TREE;
          state_d   = S_EMIT;
        end else begin
          st_req_o.rd_en = 1'b1;
          st_rd_addr_o   = VW'(row_q);
          state_d        = S_C_ACC;
        end
      end
      S_C_ACC: begin
        if (keep[VW'(row_q)]) begin
          cnt_d = cnt_q + pop_sum;
        end
        row_d   = row_q + NW'(1);
        state_d = S_C_RD;
      end
      S_EMIT: begin
        if (res_free_i) begin
          res_valid_o = 1'b1;
          if (last_v) begin
            state_d = S_IDLE;
          end else begin
            v_d     = v_q + VW'(1);
            state_d = S_W_INIT;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign res_o.vertex  = VtxW'(v_q);
  assign res_o.verdict = verdict_q;
  assign res_o.last    = last_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      s_q       <= '0;
      d_q       <= '0;
      dup_q     <= 1'b0;
      v_q       <= '0;
      sp_q      <= '0;
      visited_q <= '0;
      nb_q      <= '0;
      row_q     <= '0;
      cnt_q     <= '0;
      verdict_q <= VERDICT_TREE;
    end else begin
      state_q   <= state_d;
      s_q       <= s_d;
      d_q       <= d_d;
      dup_q     <= dup_d;
      v_q       <= v_d;
      sp_q      <= sp_d;
      visited_q <= visited_d;
      nb_q      <= nb_d;
      row_q     <= row_d;
      cnt_q     <= cnt_d;
      verdict_q <= verdict_d;
    end
  end

  // Walk stack; every entry is written before the walk pops it.
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rd_q <= stk_mem[stk_raddr];
    end
  end

endmodule

@@ hw/rtl/vertex_removal_tree_check_top.sv @@
// Top level of the vertex removal tree check block.
//
// The block holds an undirected graph of up to MAX_V vertices. Each input
// transaction carries a mode in s_axis_tuser: clear the graph, add the edge
// between the two vertices in s_axis_tdata, or evaluate. Self-loops, repeats
// and endpoints at or beyond the vertex count add no new edge; a repeat is
// remembered and counts as one extra edge. An edge insertion is a
// read-modify-write of both rows in the shared row memory. Evaluation
// removes each vertex v in turn and produces one output transaction per v:
// tree, not connected or has cycles, with tlast on the final vertex. Per
// removed vertex the sequencer walks the remaining vertices with an explicit
// stack, one reached vertex at a time, then counts the kept edges row by row
// over the n-vertex graph, and then emits the verdict.
// s_axis_tready is high only while the sequencer is idle. A single output
// register holds each verdict; while the receiver stalls, the sequencer
// waits before the next verdict. Reset empties the graph and sets the
// vertex count to 16. Write cfg_wdata_i only while the block is idle.
module vertex_removal_tree_check_top
  import vrtc_pkg::*;
#(
  parameter int unsigned MAX_V = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [VcountW-1:0] cfg_wdata_i,    // vertex_count
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // src_vertex[3:0], dst_vertex[7:4]
  input  logic [ModeW-1:0]   s_axis_tuser,   // mode[1:0]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,   // removed_vertex[3:0], verdict[5:4], zeros
  output logic               m_axis_tlast
);

  localparam int unsigned VW = (MAX_V > 1) ? $clog2(MAX_V) : 1;
  localparam int unsigned NW = $clog2(MAX_V + 1);

  logic [VcountW-1:0] vcount_q;
  logic [NW-1:0]      n_eff;

  store_req_t       st_req;
  logic [VW-1:0]    st_rd_addr, st_wr_addr;
  logic [MAX_V-1:0] st_wr_adj, st_wr_rep, st_rd_adj, st_rd_rep;

  logic    res_valid, res_free;
  result_t res;
  logic    out_valid_q;
  result_t out_q;

  // Vertex count register; the value in use is saturated into 2 .. MAX_V.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VcountReset;
    end else if (cfg_we_i) begin
      vcount_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (vcount_q < VcountW'(2)) begin
      n_eff = NW'(2);
    end else if (32'(vcount_q) > MAX_V) begin
      n_eff = NW'(MAX_V);
    end else begin
      n_eff = NW'(vcount_q);
    end
  end

  vrtc_graph_store #(
    .MAX_V(MAX_V)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (st_req),
    .rd_addr_i(st_rd_addr),
    .wr_addr_i(st_wr_addr),
    .wr_adj_i (st_wr_adj),
    .wr_rep_i (st_wr_rep),
    .rd_adj_o (st_rd_adj),
    .rd_rep_o (st_rd_rep)
  );

  vrtc_ctrl #(
    .MAX_V(MAX_V)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_i         (n_eff),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .mode_i      (s_axis_tuser),
    .src_i       (s_axis_tdata[3:0]),
    .dst_i       (s_axis_tdata[7:4]),
    .res_free_i  (res_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .st_req_o    (st_req),
    .st_rd_addr_o(st_rd_addr),
    .st_wr_addr_o(st_wr_addr),
    .st_wr_adj_o (st_wr_adj),
    .st_wr_rep_o (st_wr_rep),
    .st_rd_adj_i (st_rd_adj),
    .st_rd_rep_i (st_rd_rep)
  );

  // Output register: a new verdict may enter as the held one leaves.
  assign res_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_free && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.verdict, out_q.vertex};
  assign m_axis_tlast  = out_q.last;

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the vertex removal tree check block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vrtc_pkg::*;

  localparam int unsigned MaxV = 16;

  // Mode code that the block must accept and drop without any verdict.
  localparam logic [ModeW-1:0] ModeUnused = 2'd3;

  // About 480 meaningful input transactions; the last part runs without idling.
  localparam int unsigned ItemTarget = 480;
  localparam int unsigned CalmFrom = ItemTarget * 85 / 100;

  // An edge insertion produces no verdict, so a short settle time covers it
  // before a register write.
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned TailCycles = 200;

  // Long receiver hold-off, well beyond one verdict time, so the single output
  // register fills and the sequencer blocks the input side.
  localparam int unsigned LongHold = 400;

  // Worst case: every transaction an evaluate at 16 vertices, 16 verdicts
  // each plus receiver stalls, about 2 ms. Allow five times that.
  localparam int unsigned TimeoutNs = 10_000_000;

  typedef struct {
    logic [VtxW-1:0] a;
    logic [VtxW-1:0] b;
  } link_t;

  // Holds a private copy of the graph and the vertex count, predicts the
  // verdicts of every evaluate transaction and checks them in order.
  class VerdictScoreboard;
    logic [MaxV-1:0]    adj_rows [MaxV];
    logic [MaxV-1:0]    dup_rows [MaxV];
    logic [VcountW-1:0] vcount;
    result_t            verdict_q [$];
    int unsigned        mismatches;

    function new();
      foreach (adj_rows[i]) begin
        adj_rows[i] = '0;
        dup_rows[i] = '0;
      end
      vcount     = VcountReset;
      mismatches = 0;
    endfunction

    function void set_vertex_count(logic [VcountW-1:0] value);
      vcount = value;
    endfunction

    // Out-of-range counts saturate into 2 .. MaxV.
    function int active_vertices();
      if (vcount < 2) return 2;
      if (vcount > MaxV) return MaxV;
      return int'(vcount);
    endfunction

    // Depth-first walk with a bounded explicit stack; returns reached vertices.
    function logic [MaxV-1:0] reach_from(int start, logic [MaxV-1:0] keep);
      logic [VtxW-1:0] stk [MaxV];
      logic [MaxV-1:0] seen;
      logic [MaxV-1:0] nbrs;
      int              sp;
      seen     = '0;
      seen[start] = 1'b1;
      stk[0]   = VtxW'(start);
      sp       = 1;
      while (sp > 0) begin
        sp--;
        nbrs = adj_rows[stk[sp]] & keep & ~seen;
        for (int w = 0; w < MaxV; w++) begin
          if (nbrs[w] && sp < MaxV) begin
            seen[w] = 1'b1;
            stk[sp] = VtxW'(w);
            sp++;
          end
        end
      end
      return seen;
    endfunction

    // Edges among the kept vertices, each repeated edge counting once more.
    function int kept_edges(logic [MaxV-1:0] keep);
      logic [MaxV-1:0] above;
      int              total;
      total = 0;
      for (int i = 0; i < MaxV; i++) begin
        if (keep[i]) begin
          above = {MaxV{1'b1}} << (i + 1);
          total += $countones(adj_rows[i] & keep & above);
          total += $countones(dup_rows[i] & keep & above);
        end
      end
      return total;
    endfunction

    function void note_item(logic [ModeW-1:0] mode, logic [VtxW-1:0] src,
                            logic [VtxW-1:0] dst);
      int              n;
      logic [MaxV-1:0] all;
      logic [MaxV-1:0] keep;
      logic [MaxV-1:0] seen;
      result_t         r;
      n = active_vertices();
      case (mode)
        MODE_CLEAR: begin
          foreach (adj_rows[i]) begin
            adj_rows[i] = '0;
            dup_rows[i] = '0;
          end
        end
        MODE_ADD: begin
          if (src != dst && src < n && dst < n) begin
            if (adj_rows[src][dst]) begin
              dup_rows[src][dst] = 1'b1;
              dup_rows[dst][src] = 1'b1;
            end
            adj_rows[src][dst] = 1'b1;
            adj_rows[dst][src] = 1'b1;
          end
        end
        MODE_EVAL: begin
          all = {MaxV{1'b1}} >> (MaxV - n);
          for (int v = 0; v < n; v++) begin
            keep = all;
            keep[v] = 1'b0;
            seen = reach_from((v + 1) % n, keep);
            r.vertex = VtxW'(v);
            r.last   = (v == n - 1);
            if ((seen & keep) != keep) r.verdict = VERDICT_DISC;
            else if (kept_edges(keep) != n - 2) r.verdict = VERDICT_CYCLE;
            else r.verdict = VERDICT_TREE;
            verdict_q.push_back(r);
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(logic [VtxW-1:0] vertex, logic [VerdictW-1:0] verdict,
                               logic last);
      result_t want;
      if (verdict_q.size() == 0) begin
        $error("unexpected verdict: removed_vertex %0d verdict %0d last %0d",
               vertex, verdict, last);
        mismatches++;
        return;
      end
      want = verdict_q.pop_front();
      if (vertex !== want.vertex) begin
        $error("removed_vertex: expected %0d, got %0d", want.vertex, vertex);
        mismatches++;
      end
      if (verdict !== want.verdict) begin
        $error("verdict (vertex %0d): expected %0d, got %0d", want.vertex,
               want.verdict, verdict);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last (vertex %0d): expected %0d, got %0d", want.vertex, want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [VcountW-1:0] cfg_wdata_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata;   // src_vertex[3:0], dst_vertex[7:4]
  logic [ModeW-1:0]   s_axis_tuser;   // mode[1:0]
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [7:0]         m_axis_tdata;   // removed_vertex[3:0], verdict[5:4], zeros
  logic               m_axis_tlast;

  VerdictScoreboard sb;
  int unsigned      item_count = 0;
  bit               calm = 1'b0;
  // The sender bumps the request count; the receiver serves it on its own.
  int unsigned      hold_requests = 0;
  int unsigned      hold_served = 0;

  vertex_removal_tree_check_top #(
    .MAX_V(MaxV)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // Offers one transaction and returns at the edge where it is accepted. The
  // valid stays high afterwards so back-to-back transactions need no gap.
  task automatic send_item(input logic [ModeW-1:0] mode, input logic [VtxW-1:0] src,
                           input logic [VtxW-1:0] dst);
    int n;
    n = sb.active_vertices();
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dst, src};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(mode, src, dst);
    // Dropped transactions (mode 3, self-loops, far endpoints) are not counted.
    if (mode != ModeUnused && !(mode == MODE_ADD && (src == dst || src >= n || dst >= n)))
      item_count++;
    if (item_count >= CalmFrom) calm = 1'b1;
  endtask

  // Stops offering, waits for every predicted verdict, then lets the block
  // finish any edge insertion still in flight.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.verdict_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Register write; only called right after settle() or reset.
  task automatic write_count(input logic [VcountW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    sb.set_vertex_count(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_link(input link_t lk);
    if ($urandom_range(0, 1)) send_item(MODE_ADD, lk.b, lk.a);
    else send_item(MODE_ADD, lk.a, lk.b);
  endtask

  // A transaction the block should drop or that disturbs the planned graph.
  task automatic send_noise(input int n);
    logic [VtxW-1:0] v;
    v = VtxW'($urandom_range(0, MaxV - 1));
    case ($urandom_range(0, 3))
      0: send_item(MODE_ADD, v, v);
      1: begin
        if (n < MaxV) send_item(MODE_ADD, VtxW'($urandom_range(n, MaxV - 1)), v);
        else send_item(MODE_ADD, v, VtxW'($urandom_range(0, MaxV - 1)));
      end
      2: send_item(ModeUnused, v, VtxW'($urandom_range(0, MaxV - 1)));
      default: send_item(MODE_ADD, VtxW'($urandom_range(0, n - 1)),
                         VtxW'($urandom_range(0, n - 1)));
    endcase
  endtask

  // One phase: pick a vertex count, mostly clear, load a well-formed graph
  // (tree, ring, tree plus chords, tree with a repeat, or dense) in random
  // order with some noise, then evaluate, sometimes more than once.
  task automatic random_phase();
    int          n;
    int          j;
    int          tmp;
    int          order [MaxV];
    link_t       links [$];
    link_t       lk;
    logic [VcountW-1:0] cnt;
    settle();
    case ($urandom_range(0, 9))
      0: cnt = $urandom_range(0, 1) ? VcountW'($urandom_range(0, 1))
                                    : VcountW'($urandom_range(MaxV + 1, 31));
      1: cnt = VcountW'(MaxV);
      2: cnt = 5'd2;
      default: cnt = VcountW'($urandom_range(3, MaxV - 1));
    endcase
    write_count(cnt);
    n = sb.active_vertices();

    if ($urandom_range(0, 4) != 0)
      send_item(MODE_CLEAR, VtxW'($urandom_range(0, 15)), VtxW'($urandom_range(0, 15)));

    for (int i = 0; i < MaxV; i++) order[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end

    case ($urandom_range(0, 4))
      1: begin
        for (int i = 0; i < n; i++)
          links.push_back('{a: VtxW'(order[i]), b: VtxW'(order[(i + 1) % n])});
      end
      4: begin
        for (int a = 0; a < n; a++)
          for (int b = a + 1; b < n; b++)
            if ($urandom_range(0, 2) == 0) links.push_back('{a: VtxW'(a), b: VtxW'(b)});
      end
      default: begin
        for (int i = 1; i < n; i++)
          links.push_back('{a: VtxW'(order[i]), b: VtxW'(order[$urandom_range(0, i - 1)])});
        if (links.size() > 0 && $urandom_range(0, 2) == 0)
          links.push_back(links[$urandom_range(0, links.size() - 1)]);
        else if ($urandom_range(0, 1) == 0)
          repeat ($urandom_range(1, 2))
            links.push_back('{a: VtxW'($urandom_range(0, n - 1)),
                              b: VtxW'($urandom_range(0, n - 1))});
      end
    endcase

    for (int i = links.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      lk = links[i];
      links[i] = links[j];
      links[j] = lk;
    end
    foreach (links[i]) begin
      if ($urandom_range(0, 9) == 0) send_noise(n);
      send_link(links[i]);
    end

    send_item(MODE_EVAL, VtxW'($urandom_range(0, 15)), VtxW'($urandom_range(0, 15)));
    if (hold_requests == 0 || (!calm && $urandom_range(0, 9) == 0)) begin
      // Receiver stalls for a long time while the next evaluate is offered.
      hold_requests++;
      send_item(MODE_EVAL, VtxW'($urandom_range(0, 15)), VtxW'($urandom_range(0, 15)));
    end else if ($urandom_range(0, 2) == 0) begin
      send_item(MODE_ADD, VtxW'($urandom_range(0, n - 1)), VtxW'($urandom_range(0, n - 1)));
      send_item(MODE_EVAL, VtxW'($urandom_range(0, 15)), VtxW'($urandom_range(0, 15)));
    end
  endtask

  // Receiver: checks each accepted verdict and applies random stalls, plus
  // the long hold-off whenever the sender asks for one.
  initial begin
    int unsigned hold_left;
    int unsigned stall_left;
    hold_left  = 0;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata[3:0], m_axis_tdata[5:4], m_axis_tlast);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Stimulus and end of test.
  initial begin
    sb = new();
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= MODE_CLEAR;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset count of 16: corner endpoints, a repeated edge given in both
    // orders and then a third time, a self-loop, an edge that a later smaller
    // count hides, and the unused mode.
    send_item(MODE_ADD, 4'd0, 4'd15);
    send_item(MODE_ADD, 4'd15, 4'd0);
    send_item(MODE_ADD, 4'd0, 4'd15);
    send_item(MODE_ADD, 4'd7, 4'd7);
    send_item(MODE_ADD, 4'd3, 4'd12);
    send_item(ModeUnused, 4'd15, 4'd15);
    send_item(MODE_EVAL, 4'd15, 4'd15);

    // Five vertices on a ring: every removal leaves a path. The stored edges
    // above the count and an endpoint beyond it must all be ignored.
    settle();
    write_count(5'd5);
    send_item(MODE_ADD, 4'd0, 4'd1);
    send_item(MODE_ADD, 4'd1, 4'd2);
    send_item(MODE_ADD, 4'd2, 4'd3);
    send_item(MODE_ADD, 4'd3, 4'd4);
    send_item(MODE_ADD, 4'd4, 4'd0);
    send_item(MODE_ADD, 4'd4, 4'd9);
    send_item(MODE_EVAL, 4'd0, 4'd0);

    // Smallest graph: a single edge is a tree per removal, and so is its repeat.
    settle();
    write_count(5'd2);
    send_item(MODE_CLEAR, 4'd15, 4'd15);
    send_item(MODE_ADD, 4'd0, 4'd1);
    send_item(MODE_EVAL, 4'd0, 4'd0);
    send_item(MODE_ADD, 4'd1, 4'd0);
    send_item(MODE_EVAL, 4'd0, 4'd0);

    // Counts below and above the legal range saturate.
    settle();
    write_count(5'd0);
    send_item(MODE_EVAL, 4'd0, 4'd0);
    settle();
    write_count(5'd31);
    send_item(MODE_EVAL, 4'd0, 4'd0);

    while (item_count < ItemTarget) random_phase();

    settle();
    repeat (TailCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.verdict_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/vrtc_pkg.sv
hw/rtl/vrtc_graph_store.sv
hw/rtl/vrtc_ctrl.sv
hw/rtl/vertex_removal_tree_check_top.sv
verif/tb.sv
